// ===== rtl/lfo_tremolo_amplitude_modulator_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LFO_TREMOLO_AMPLITUDE_MODULATOR_TOP_DEFINES_SVH
`define LFO_TREMOLO_AMPLITUDE_MODULATOR_TOP_DEFINES_SVH

// Property checked only while reset is low.
`define LT_ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LT_ASSERT_RAW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lfo_trem_pkg.sv =====
`timescale 1ns / 1ps
package lfo_trem_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_POS_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_IDX_W = SINE_POS_W + 1;
  localparam int LFO_W = 24;
  localparam int GAIN_W = 16;
  localparam int ACC_W = SAMPLE_BITS + 17;
  localparam int MUL_A_W = SAMPLE_BITS + 18;
  localparam int MUL_P_W = MUL_A_W + GAIN_W;
  localparam int MUL_CNT_W = $clog2(GAIN_W);

  localparam logic signed [LFO_W-1:0] LFO_MAX = {1'b0, {(LFO_W-1){1'b1}}};
  localparam logic signed [LFO_W-1:0] LFO_MIN = {1'b1, {(LFO_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;
  localparam longint CLIP_LIMIT = ((64'd1 << (SAMPLE_BITS - 1)) * 999) / 1000;

  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_PHASE_OFFSET = 3'd1;
  localparam logic [2:0] REG_WAVE_SELECT = 3'd2;
  localparam logic [2:0] REG_DEPTH_GAIN = 3'd3;
  localparam logic [2:0] REG_WET_GAIN = 3'd4;
  localparam logic [2:0] REG_DRY_GAIN = 3'd5;
  localparam logic [2:0] REG_MASTER_VOLUME = 3'd6;
  localparam logic [2:0] REG_SMOOTH_COEF = 3'd7;

  localparam logic [1:0] WAVE_SINE = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_SAW = 2'd3;

  typedef logic [LFO_W-2:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      r = (sum + 64) / 128;
      if (r < 0) begin
        r = 0;
      end
      if (r > 64'sd8388607) begin
        r = 64'sd8388607;
      end
      rom[i] = r[LFO_W-2:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  function automatic logic [GAIN_W-1:0] cap_q15(logic [GAIN_W-1:0] g);
    return (g > Q15_ONE) ? Q15_ONE : g;
  endfunction

endpackage

// ===== rtl/lfo_trem_wave.sv =====
`timescale 1ns / 1ps
module lfo_trem_wave (
  input  logic [31:0]                           phase,
  input  logic [1:0]                            wave_select,
  output logic signed [lfo_trem_pkg::LFO_W-1:0] lfo
);

  logic [lfo_trem_pkg::SINE_POS_W-1:0] pos;
  logic [lfo_trem_pkg::SINE_IDX_W-1:0] idx;
  logic signed [lfo_trem_pkg::LFO_W-1:0] sine_v;
  logic [22:0] frac;
  logic signed [26:0] tri_v;
  logic signed [26:0] saw_v;

  always_comb begin
    pos = phase[29 -: lfo_trem_pkg::SINE_POS_W];
    if (phase[30]) begin
      idx = lfo_trem_pkg::SINE_IDX_W'(lfo_trem_pkg::SINE_TABLE_DEPTH) - {1'b0, pos};
    end else begin
      idx = {1'b0, pos};
    end
    sine_v = $signed({1'b0, lfo_trem_pkg::SINE_ROM[idx]});
    if (phase[31]) begin
      sine_v = -sine_v;
    end
    frac = phase[31:9];
    if (!frac[22]) begin
      tri_v = $signed({2'b00, frac, 2'b00}) - 27'sd8388608;
    end else begin
      tri_v = 27'sd25165824 - $signed({2'b00, frac, 2'b00});
    end
    if (tri_v > 27'sd8388607) begin
      tri_v = 27'sd8388607;
    end
    saw_v = $signed({3'b000, frac, 1'b0}) - 27'sd8388608;
    unique case (wave_select)
      lfo_trem_pkg::WAVE_SINE: lfo = sine_v;
      lfo_trem_pkg::WAVE_TRIANGLE: lfo = tri_v[lfo_trem_pkg::LFO_W-1:0];
      lfo_trem_pkg::WAVE_SQUARE: lfo = phase[31] ? lfo_trem_pkg::LFO_MIN : lfo_trem_pkg::LFO_MAX;
      lfo_trem_pkg::WAVE_SAW: lfo = saw_v[lfo_trem_pkg::LFO_W-1:0];
      default: lfo = '0;
    endcase
  end

endmodule

// ===== rtl/lfo_trem_mul.sv =====
`timescale 1ns / 1ps
module lfo_trem_mul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [lfo_trem_pkg::MUL_A_W-1:0] a,
  input  logic [lfo_trem_pkg::GAIN_W-1:0]         b,
  output logic                                    done,
  output logic signed [lfo_trem_pkg::MUL_P_W-1:0] p
);

  // Multiplier bits are consumed most significant first, one per cycle.
  logic signed [lfo_trem_pkg::MUL_P_W-1:0] acc;
  logic signed [lfo_trem_pkg::MUL_A_W-1:0] a_reg;
  logic [lfo_trem_pkg::GAIN_W-1:0] b_reg;
  logic [lfo_trem_pkg::MUL_CNT_W-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lfo_trem_pkg::MUL_CNT_W'(lfo_trem_pkg::GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_reg <= a;
      b_reg <= b;
    end else if (busy) begin
      acc <= (acc <<< 1) + (b_reg[lfo_trem_pkg::GAIN_W-1] ?
             lfo_trem_pkg::MUL_P_W'(a_reg) : '0);
      b_reg <= b_reg << 1;
    end
  end

  assign p = acc;

endmodule

// ===== rtl/lfo_tremolo_amplitude_modulator_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// input    in_valid / in_ready    sample_in (24-bit signed)
// output   out_valid / out_ready  sample_out (24-bit signed)
// config   cfg_we                 cfg_index, cfg_data
// Each request runs one shared bit-serial multiplier six times in turn,
// and the output register is loaded after the last run.
// A new request is taken once the previous one has reached the output register,
// so the block does not accept a new request while one is in progress.
// A result held by a low out_ready waits in the output register and stalls the block.
// Reset restores the register defaults and clears the LFO phase and smoothing state.
module lfo_tremolo_amplitude_modulator_top (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [lfo_trem_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [lfo_trem_pkg::SAMPLE_BITS-1:0] sample_out,
  input  logic                                        cfg_we,
  input  logic [2:0]                                  cfg_index,
  input  logic [31:0]                                 cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] OP_FILT = 3'd0;
  localparam logic [2:0] OP_DEPTH = 3'd1;
  localparam logic [2:0] OP_PROC = 3'd2;
  localparam logic [2:0] OP_DRY = 3'd3;
  localparam logic [2:0] OP_WET = 3'd4;
  localparam logic [2:0] OP_VOL = 3'd5;

  localparam int SB = lfo_trem_pkg::SAMPLE_BITS;
  localparam int AW = lfo_trem_pkg::MUL_A_W;
  localparam int PW = lfo_trem_pkg::MUL_P_W;
  localparam int LW = lfo_trem_pkg::LFO_W;
  localparam logic signed [PW-1:0] LIMIT_P = PW'(lfo_trem_pkg::CLIP_LIMIT);

  logic [23:0] phase_step;
  logic [31:0] phase_offset;
  logic [1:0] wave_select;
  logic [15:0] depth_gain;
  logic [15:0] wet_gain;
  logic [15:0] dry_gain;
  logic [15:0] master_volume;
  logic [15:0] smooth_coef;

  logic [1:0] state;
  logic [2:0] op;
  logic [31:0] phase;
  logic [31:0] phase_next;
  logic signed [LW-1:0] lfo;
  logic signed [LW-1:0] lfo_next;
  logic signed [LW-1:0] y;
  logic signed [SB-1:0] x;
  logic [15:0] modv;
  logic signed [SB:0] proc;
  logic signed [lfo_trem_pkg::ACC_W-1:0] acc;
  logic signed [SB-1:0] res;

  logic mul_start;
  logic mul_done;
  logic signed [AW-1:0] mul_a;
  logic [15:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] p_r15;
  logic signed [PW-1:0] p_r24;
  logic signed [PW-1:0] p_r30;
  logic signed [LW+1:0] ysum;

  assign phase_next = phase + 32'(phase_step);
  assign in_ready = (state == ST_IDLE);
  assign mul_start = (state == ST_LOAD);

  lfo_trem_wave u_wave (
    .phase       (phase_next + phase_offset),
    .wave_select (wave_select),
    .lfo         (lfo_next)
  );

  lfo_trem_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    unique case (op)
      OP_FILT: begin
        mul_a = AW'(lfo) - AW'(y);
        mul_b = lfo_trem_pkg::cap_q15(smooth_coef);
      end
      OP_DEPTH: begin
        mul_a = AW'(y) + (AW'(1) <<< (LW - 1));
        mul_b = lfo_trem_pkg::cap_q15(depth_gain);
      end
      OP_PROC: begin
        mul_a = AW'(x);
        mul_b = modv;
      end
      OP_DRY: begin
        mul_a = AW'(x);
        mul_b = lfo_trem_pkg::cap_q15(dry_gain);
      end
      OP_WET: begin
        mul_a = AW'(proc);
        mul_b = lfo_trem_pkg::cap_q15(wet_gain);
      end
      OP_VOL: begin
        mul_a = AW'(acc);
        mul_b = lfo_trem_pkg::cap_q15(master_volume);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    p_r15 = (mul_p + (PW'(1) <<< 14)) >>> 15;
    p_r24 = (mul_p + (PW'(1) <<< 23)) >>> 24;
    p_r30 = (mul_p + (PW'(1) <<< 29)) >>> 30;
    ysum = (LW + 2)'(y) + (LW + 2)'(p_r15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= 24'd447392;
      phase_offset <= '0;
      wave_select <= lfo_trem_pkg::WAVE_SINE;
      depth_gain <= 16'd16384;
      wet_gain <= 16'd32768;
      dry_gain <= '0;
      master_volume <= 16'd32768;
      smooth_coef <= 16'd215;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfo_trem_pkg::REG_PHASE_STEP: phase_step <= cfg_data[23:0];
        lfo_trem_pkg::REG_PHASE_OFFSET: phase_offset <= cfg_data;
        lfo_trem_pkg::REG_WAVE_SELECT: wave_select <= cfg_data[1:0];
        lfo_trem_pkg::REG_DEPTH_GAIN: depth_gain <= cfg_data[15:0];
        lfo_trem_pkg::REG_WET_GAIN: wet_gain <= cfg_data[15:0];
        lfo_trem_pkg::REG_DRY_GAIN: dry_gain <= cfg_data[15:0];
        lfo_trem_pkg::REG_MASTER_VOLUME: master_volume <= cfg_data[15:0];
        lfo_trem_pkg::REG_SMOOTH_COEF: smooth_coef <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_FILT;
      phase <= '0;
      y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            phase <= phase_next;
            op <= OP_FILT;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (mul_done) begin
            if (op == OP_VOL) begin
              state <= ST_DONE;
            end else begin
              op <= op + 1'b1;
              state <= ST_LOAD;
            end
            if (op == OP_FILT) begin
              if (ysum > (LW + 2)'(lfo_trem_pkg::LFO_MAX)) begin
                y <= lfo_trem_pkg::LFO_MAX;
              end else if (ysum < (LW + 2)'(lfo_trem_pkg::LFO_MIN)) begin
                y <= lfo_trem_pkg::LFO_MIN;
              end else begin
                y <= ysum[LW-1:0];
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      x <= sample_in;
      lfo <= lfo_next;
    end
    if (state == ST_RUN && mul_done) begin
      unique case (op)
        OP_DEPTH: modv <= 16'(17'd32768 - 17'(p_r24));
        OP_PROC: proc <= (SB + 1)'(p_r15);
        OP_DRY: acc <= lfo_trem_pkg::ACC_W'(mul_p);
        OP_WET: acc <= acc + lfo_trem_pkg::ACC_W'(mul_p);
        OP_VOL: begin
          if (p_r30 > LIMIT_P) begin
            res <= SB'(LIMIT_P);
          end else if (p_r30 < -LIMIT_P) begin
            res <= SB'(-LIMIT_P);
          end else begin
            res <= SB'(p_r30);
          end
        end
        default: ;
      endcase
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      sample_out <= res;
    end
  end

endmodule

// ===== rtl/lfo_trem_checker.sv =====
`timescale 1ns / 1ps
`include "lfo_tremolo_amplitude_modulator_top_defines.svh"
module lfo_trem_checker (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        in_valid,
  input logic                                        in_ready,
  input logic                                        out_valid,
  input logic                                        out_ready,
  input logic signed [lfo_trem_pkg::SAMPLE_BITS-1:0] sample_out
);

  localparam logic signed [lfo_trem_pkg::SAMPLE_BITS-1:0] LIM =
    lfo_trem_pkg::SAMPLE_BITS'(lfo_trem_pkg::CLIP_LIMIT);

  `LT_ASSERT_PROP(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)), "stalled result changed")
  `LT_ASSERT_PROP(a_out_clip, clk, rst, out_valid |-> (sample_out <= LIM && sample_out >= -LIM), "result beyond clip limit")
  `LT_ASSERT_PROP(a_busy_after_req, clk, rst, (in_valid && in_ready) |=> !in_ready, "request taken while busy")
  `LT_ASSERT_RAW(a_reset_empty, clk, rst |=> (!out_valid && in_ready), "state not cleared by reset")

endmodule

bind lfo_tremolo_amplitude_modulator_top lfo_trem_checker u_lfo_trem_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lfo_trem_pkg::*;

  localparam int  STALL_LIMIT = 3000;
  localparam int  HOLD_CYCLES = 600;
  localparam int  PLAN_LEN = 26;
  localparam longint LIMIT = 8380219;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  lfo_tremolo_amplitude_modulator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    bit is_cfg;
    logic [2:0] idx;
    logic [31:0] val;
    logic signed [SAMPLE_BITS-1:0] smp;
    bit typed;
    logic signed [SAMPLE_BITS-1:0] want;
  } plan_row_t;

  longint quarter_sine [0:SINE_TABLE_DEPTH];
  logic [23:0] step_r;
  logic [31:0] offset_r;
  logic [1:0] wave_r;
  logic [15:0] depth_r, wet_r, dry_r, volume_r, coef_r;
  logic [31:0] lfo_acc;
  longint smooth_lfo;

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  int mismatches;
  int samples_sent;
  int samples_checked;
  int idle_cycles;
  bit hold_req;
  bit hold_taken;
  int hold_left;
  int rx_cycle;
  int burst_left;
  plan_row_t plan [0:PLAN_LEN-1];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_sine();
    logic [63:0] x, term;
    longint acc;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      acc = (acc + 64) / 128;
      if (acc < 0) acc = 0;
      if (acc > 8388607) acc = 8388607;
      quarter_sine[i] = acc;
    end
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat_gain(logic [15:0] g);
    return (g > 16'd32768) ? 32768 : longint'(g);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_PHASE_STEP: step_r = val[23:0];
      REG_PHASE_OFFSET: offset_r = val;
      REG_WAVE_SELECT: wave_r = val[1:0];
      REG_DEPTH_GAIN: depth_r = val[15:0];
      REG_WET_GAIN: wet_r = val[15:0];
      REG_DRY_GAIN: dry_r = val[15:0];
      REG_MASTER_VOLUME: volume_r = val[15:0];
      REG_SMOOTH_COEF: coef_r = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] tremolo_predict(
      logic signed [SAMPLE_BITS-1:0] s);
    logic [31:0] ph;
    longint frac, lfo, y, gain, proc, acc, r;
    int pos;
    lfo_acc = lfo_acc + 32'(step_r);
    ph = lfo_acc + offset_r;
    frac = longint'(ph >> 9);
    case (wave_r)
      WAVE_SINE: begin
        pos = int'(ph[29:22]);
        if (ph[30]) pos = SINE_TABLE_DEPTH - pos;
        lfo = ph[31] ? -quarter_sine[pos] : quarter_sine[pos];
      end
      WAVE_TRIANGLE: lfo = (frac < 4194304) ? 4 * frac - 8388608 : 25165824 - 4 * frac;
      WAVE_SQUARE: lfo = (frac < 4194304) ? 8388607 : -8388608;
      default: lfo = 2 * frac - 8388608;
    endcase
    if (lfo > 8388607) lfo = 8388607;
    y = smooth_lfo + rnd_shift(sat_gain(coef_r) * (lfo - smooth_lfo), 15);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    smooth_lfo = y;
    gain = 32768 - rnd_shift(sat_gain(depth_r) * (8388608 + y), 24);
    proc = rnd_shift(longint'(s) * gain, 15);
    acc = longint'(s) * sat_gain(dry_r) + proc * sat_gain(wet_r);
    r = rnd_shift(acc * sat_gain(volume_r), 30);
    if (r > LIMIT) r = LIMIT;
    if (r < -LIMIT) r = -LIMIT;
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, bit typed,
                             logic signed [SAMPLE_BITS-1:0] want);
    logic signed [SAMPLE_BITS-1:0] predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    predicted = tremolo_predict(s);
    pending_samples.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'sh7FFFFF - $urandom_range(0, 255)
                                     : 24'sh800000 + $urandom_range(0, 255);
      1: return $urandom_range(0, 511) - 256;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if ((rx_cycle / 300) % 2 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) && (rx_cycle % 11 != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      samples_checked++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output sample %0d", sample_out);
      end else begin
        if (sample_out !== pending_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d, got %0d",
                     pending_samples[0], sample_out);
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] gain_pick [0:4];
    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    samples_checked = 0;
    burst_left = 0;
    fill_sine();
    apply_reg(REG_PHASE_STEP, 447392);
    apply_reg(REG_PHASE_OFFSET, 0);
    apply_reg(REG_WAVE_SELECT, WAVE_SINE);
    apply_reg(REG_DEPTH_GAIN, 16384);
    apply_reg(REG_WET_GAIN, 32768);
    apply_reg(REG_DRY_GAIN, 0);
    apply_reg(REG_MASTER_VOLUME, 32768);
    apply_reg(REG_SMOOTH_COEF, 215);
    lfo_acc = '0;
    smooth_lfo = 0;
    gain_pick = '{0, 1, 32768, 32769, 65535};

    plan = '{
      '{0, REG_PHASE_STEP, 0, 24'sd0, 1, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh7FFFFF, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh800000, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sd1, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, -24'sd1, 0, 24'sd0},
      '{1, REG_DRY_GAIN, 32768, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh7FFFFF, 1, 24'sd8380219},
      '{0, REG_PHASE_STEP, 0, 24'sh800000, 1, -24'sd8380219},
      '{1, REG_DRY_GAIN, 0, 24'sd0, 0, 24'sd0},
      '{1, REG_WAVE_SELECT, WAVE_TRIANGLE, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh400000, 0, 24'sd0},
      '{1, REG_PHASE_OFFSET, 32'h8000_0000, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, -24'sh400000, 0, 24'sd0},
      '{1, REG_WAVE_SELECT, WAVE_SQUARE, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh600000, 0, 24'sd0},
      '{1, REG_WAVE_SELECT, WAVE_SAW, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh600000, 0, 24'sd0},
      '{1, REG_DEPTH_GAIN, 65535, 24'sd0, 0, 24'sd0},
      '{1, REG_SMOOTH_COEF, 65535, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh7FFFFF, 0, 24'sd0},
      '{1, REG_PHASE_STEP, 32'h00FF_FFFF, 24'sd0, 0, 24'sd0},
      '{1, REG_PHASE_OFFSET, 32'hFFFF_FFFF, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh800000, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh7FFFFF, 0, 24'sd0},
      '{1, REG_MASTER_VOLUME, 0, 24'sd0, 0, 24'sd0},
      '{0, REG_PHASE_STEP, 0, 24'sh7FFFFF, 1, 24'sd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we <= 1'b0;
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      write_reg(REG_PHASE_STEP, (ph % 3 == 0) ? $urandom_range(0, 32'hFFFFFF)
                                              : $urandom_range(0, 8388608));
      write_reg(REG_PHASE_OFFSET, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_WAVE_SELECT, ph % 4);
      write_reg(REG_DEPTH_GAIN, (ph < 5) ? gain_pick[ph] : $urandom_range(0, 32768));
      write_reg(REG_WET_GAIN, (ph < 5) ? gain_pick[4 - ph] : $urandom_range(0, 32768));
      write_reg(REG_DRY_GAIN, (ph < 5) ? gain_pick[(ph + 2) % 5]
                                       : $urandom_range(0, 32768));
      write_reg(REG_MASTER_VOLUME, (ph < 5) ? gain_pick[(ph + 3) % 5]
                                            : $urandom_range(16384, 32768));
      write_reg(REG_SMOOTH_COEF, (ph < 5) ? gain_pick[(ph + 1) % 5]
                                          : $urandom_range(0, 4096));
      cfg_we <= 1'b0;
      if (ph == 3) hold_req <= 1'b1;
      repeat (78) send_sample(random_sample(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d samples and checked %0d outputs over all four LFO shapes,",
             samples_sent, samples_checked);
    $display("with every register written at its extremes and a long output stall.");
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lfo_trem_pkg.sv
rtl/lfo_trem_wave.sv
rtl/lfo_trem_mul.sv
rtl/lfo_tremolo_amplitude_modulator_top.sv
rtl/lfo_trem_checker.sv
tb/testbench.sv
